// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the station name assembler modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== sv/rdsna_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsna_pkg
// Types, constants and the character update rule of the station name assembler.
// ----------------------------------------------------------------------------
package rdsna_pkg;

    localparam int NAME_ROWS = 4;
    localparam int ROW_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'h20;
    localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'h7E;

    localparam logic [4:0] GROUP_0A = 5'b00000;
    localparam logic [4:0] GROUP_0B = 5'b00001;

    localparam logic MODE_CLEAR = 1'b0;
    localparam logic MODE_GROUP = 1'b1;

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [CHAR_W-1:0] char_t;

    typedef struct packed {
        char_t cand_second;
        char_t cand_first;
        char_t disp_second;
        char_t disp_first;
    } row_data_t;

    localparam row_data_t ROW_RESET = '{SPACE_CHAR, SPACE_CHAR, SPACE_CHAR, SPACE_CHAR};

    typedef struct packed {
        logic      rd_en;
        row_t      rd_row;
        logic      wr_en;
        row_t      wr_row;
        row_data_t wr_data;
        logic      clr;
    } store_req_t;

    typedef struct packed {
        logic  ok;
        char_t disp;
        char_t cand;
    } char_upd_t;

    // A character equal to its candidate is confirmed; otherwise a printable
    // character becomes the new candidate.
    function automatic char_upd_t take_char(char_t disp, char_t cand, char_t ch);
        char_upd_t upd;
        upd.ok   = (cand == ch);
        upd.disp = disp;
        upd.cand = cand;
        if (upd.ok)
        begin
            upd.disp = ch;
        end
        else if ((ch >= PRINT_LOW) && (ch <= PRINT_HIGH))
        begin
            upd.cand = ch;
        end
        return upd;
    endfunction

endpackage

// ===== sv/rdsna_store.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rdsna_store
// Name store: one row per character pair, holding display and candidate
// characters, with row valid bits, a registered read and write forwarding.
// ----------------------------------------------------------------------------
module rdsna_store
    import rdsna_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_req_t req,
    output row_data_t  rd_row_data
);

    row_data_t mem [NAME_ROWS];

    row_data_t              rd_data_reg;
    row_data_t              fwd_data_reg;
    row_t                   rd_row_reg;
    logic                   fwd_hit_reg;
    logic                   fwd_hit_next;
    logic [NAME_ROWS-1:0]   valid_reg;
    logic [NAME_ROWS-1:0]   valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clr)
        begin
            valid_next = '0;
        end
        else if (req.wr_en)
        begin
            valid_next[req.wr_row] = 1'b1;
        end
    end

    always_comb
    begin
        fwd_hit_next = fwd_hit_reg;
        if (req.rd_en)
        begin
            fwd_hit_next = req.wr_en && (req.wr_row == req.rd_row);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_row] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg  <= mem[req.rd_row];
            rd_row_reg   <= req.rd_row;
            fwd_data_reg <= req.wr_data;
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            rd_row_data = fwd_data_reg;
        end
        else if (valid_reg[rd_row_reg])
        begin
            rd_row_data = rd_data_reg;
        end
        else
        begin
            rd_row_data = ROW_RESET;
        end
    end

    `ASSERT_PROP(a_write_sets_valid, clk, rst_n, req.wr_en |=> valid_reg[$past(req.wr_row)], "written row not marked valid")
    `ASSERT_PROP(a_clear_drops_valid, clk, rst_n, req.clr |=> (valid_reg == '0), "clear left a row valid")

endmodule

// ===== sv/rds_station_name_assembler.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// rds_station_name_assembler
// Assembles the 8-character RDS station name from group 0A and 0B requests.
// ----------------------------------------------------------------------------
// Input requests arrive on the s_ channel: s_tuser is the mode (0 clears both
// name stores to spaces, 1 carries one RDS group), s_tdata holds block B and
// block D. Every input request yields exactly one output request on the m_
// channel: m_tuser flags a name group, m_tdata holds the addressed segment,
// the two display characters after the update and their confirmation flags.
// Other group types and clears give an all-zero output request.
// The store row is read when a request is accepted and written back as the
// request leaves the working stage, where the output register takes its
// result. One request is accepted per cycle unless the receiver stalls;
// back-to-back requests to the same row are served by forwarding the written row.
// Reset clears the row valid bits at once, so the stores read as spaces and
// no clearing pass is needed. When the receiver stalls, the output register
// holds its request and the block keeps accepting until its single working
// stage is full as well.
// ----------------------------------------------------------------------------
module rds_station_name_assembler
    import rdsna_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // block_b[15:0], block_d[31:16]
    input  logic                 s_tuser,  // mode[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // segment[1:0], first_char[9:2],
                                           // second_char[17:10],
                                           // first_confirmed[18],
                                           // second_confirmed[19], zero[23:20]
    output logic                 m_tuser   // is_name_group[0]
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_mode_reg;
    logic [15:0]          s1_b_reg;
    logic [15:0]          s1_d_reg;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_user_reg;

    logic       out_free;
    logic       s1_go;
    logic       accept;
    logic       is_name;
    row_t       seg;
    row_data_t  row_data;
    char_upd_t  upd_first;
    char_upd_t  upd_second;
    store_req_t req;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_go    = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    assign is_name = (s1_mode_reg == MODE_GROUP)
                  && ((s1_b_reg[15:11] == GROUP_0A) || (s1_b_reg[15:11] == GROUP_0B));
    assign seg     = s1_b_reg[ROW_W-1:0];

    assign upd_first  = take_char(row_data.disp_first, row_data.cand_first, s1_d_reg[15:8]);
    assign upd_second = take_char(row_data.disp_second, row_data.cand_second, s1_d_reg[7:0]);

    always_comb
    begin
        req.rd_en               = accept;
        req.rd_row              = s_tdata[ROW_W-1:0];
        req.wr_en               = s1_go && is_name;
        req.wr_row              = seg;
        req.wr_data.disp_first  = upd_first.disp;
        req.wr_data.disp_second = upd_second.disp;
        req.wr_data.cand_first  = upd_first.cand;
        req.wr_data.cand_second = upd_second.cand;
        req.clr                 = s1_go && (s1_mode_reg == MODE_CLEAR);
    end

    rdsna_store u_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rd_row_data (row_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (s1_go)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= s_tuser;
            s1_b_reg    <= s_tdata[15:0];
            s1_d_reg    <= s_tdata[31:16];
        end
        if (s1_go)
        begin
            m_user_reg <= is_name;
            if (is_name)
            begin
                m_data_reg <= {4'b0000, upd_second.ok, upd_first.ok,
                               upd_second.disp, upd_first.disp, seg};
            end
            else
            begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `ASSERT_NEVER(a_no_write_on_clear, clk, rst_n,
                  req.wr_en && req.clr, "row write during a clear")
    `ASSERT_PROP(a_other_group_zero, clk, rst_n,
                 (m_tvalid && !m_tuser) |-> (m_tdata == '0), "non-name result carries data")

endmodule
